// ----- hdl/pqa_pkg.sv -----
// Shared types, codes and defaults for the pressure-aware queue arbiter.
`default_nettype none
package pqa_pkg;

   localparam int NUM_CPUS_DEF = 64;

   localparam logic [63:0] RECENT_SPAN_NS = 64'd1000000000;
   localparam logic [63:0] DEF_AGE       = 64'd3000000000;
   localparam logic [63:0] DEF_BYTES     = 64'd64 << 20;
   localparam logic [31:0] DEF_IMM       = 32'd1;
   localparam logic [63:0] DEF_L0_FILES  = 64'd4;
   localparam logic [31:0] DEF_FLUSH_BUD = 32'd3;
   localparam logic [31:0] DEF_L0_BUD    = 32'd2;
   localparam logic [31:0] CNT_MAX       = 32'hffffffff;

   localparam int REQ_TDATA_W = 304;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic {
      FUNC_ENQUEUE  = 1'b0,
      FUNC_DISPATCH = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CLS_UNKNOWN    = 2'd0,
      CLS_FLUSH      = 2'd1,
      CLS_COMPACTION = 2'd2,
      CLS_OTHER      = 2'd3
   } thread_class_type;

   typedef enum logic [1:0] {
      KIND_SHARED     = 2'd0,
      KIND_FLUSH      = 2'd1,
      KIND_LEVEL0     = 2'd2,
      KIND_COMPACTION = 2'd3
   } task_kind_type;

   typedef enum logic [2:0] {
      PICK_NONE       = 3'd0,
      PICK_LEVEL0     = 3'd1,
      PICK_FLUSH      = 3'd2,
      PICK_COMPACTION = 3'd3,
      PICK_SHARED     = 3'd4,
      PICK_RESCUE     = 3'd5
   } pick_type;

   typedef enum logic [1:0] {
      RUN_OTHER  = 2'd0,
      RUN_FLUSH  = 2'd1,
      RUN_LEVEL0 = 2'd2
   } run_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STALE_AGE    = 3'd0,
      CSR_BYTES_LIMIT  = 3'd1,
      CSR_IMM_LIMIT    = 3'd2,
      CSR_L0_LIMIT     = 3'd3,
      CSR_FLUSH_CAP    = 3'd4,
      CSR_L0_CAP       = 3'd5
   } csr_index_type;

   // per-CPU run counters, held side by side in one memory word
   typedef struct packed {
      logic [31:0] level0_runs;
      logic [31:0] flush_runs;
   } cnt_word_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      sat_inc = (c != CNT_MAX) ? c + 32'd1 : c;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/pqa_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
`default_nettype none
module pqa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/pressure_aware_queue_arbiter_unit.sv -----
// Top level of the pressure-aware queue arbiter: classification, dispatch and run counters.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | tuser func, tdata task and metrics fields
//  rsp     | out       | rsp_tvalid/tready  | tdata task_kind, picked_queue, both_active
//  csr     | in        | csr_valid/ready    | csr_index, csr_data (always ready)
//
// One transaction per cycle sustained unless rsp stalls; rsp stalls back up into req.
// Each request is registered in stage 1 and then in the result register. The counter
// memory is read on acceptance and written back as the item leaves stage 1; a bypass
// register with the latest update covers a read issued as that entry is written. After
// reset a clearing pass zeroes all NUM_CPUS entries, one a cycle, with req_tready low.
`default_nettype none
module pressure_aware_queue_arbiter_unit #(
   parameter int NUM_CPUS = pqa_pkg::NUM_CPUS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // from bit 0: now 64, cpu_id 6, thread_class 2, from_level_zero 1, metrics_present 1,
   // metrics_time 64, write_stall 1, immutable_count 32, memtable_bytes 64,
   // level0_files 64, queue_ready 5
   input  wire logic [pqa_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // func
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // from bit 0: task_kind 2, picked_queue 3, both_active 1, zero 2
   output logic      [pqa_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pqa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [63:0]                         csr_data
);
   import pqa_pkg::*;

   localparam int AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

   // ---------------- configuration ----------------
   logic [63:0] age_lim_ff, bytes_lim_ff, l0_lim_ff;
   logic [31:0] imm_lim_ff, flush_bud_ff, l0_bud_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_lim_ff   <= DEF_AGE;
         bytes_lim_ff <= DEF_BYTES;
         imm_lim_ff   <= DEF_IMM;
         l0_lim_ff    <= DEF_L0_FILES;
         flush_bud_ff <= DEF_FLUSH_BUD;
         l0_bud_ff    <= DEF_L0_BUD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STALE_AGE:    age_lim_ff   <= csr_data;
            CSR_BYTES_LIMIT:  bytes_lim_ff <= csr_data;
            CSR_IMM_LIMIT:    imm_lim_ff   <= csr_data[31:0];
            CSR_L0_LIMIT:     l0_lim_ff    <= csr_data;
            CSR_FLUSH_CAP:    flush_bud_ff <= csr_data[31:0];
            CSR_L0_CAP:       l0_bud_ff    <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // zero selects the default
   logic [63:0] age_thr, bytes_lvl, l0_thr;
   logic [31:0] imm_thr, flush_bud, l0_bud;
   assign age_thr   = (age_lim_ff   != '0) ? age_lim_ff   : DEF_AGE;
   assign bytes_lvl = (bytes_lim_ff != '0) ? bytes_lim_ff : DEF_BYTES;
   assign imm_thr   = (imm_lim_ff   != '0) ? imm_lim_ff   : DEF_IMM;
   assign l0_thr    = (l0_lim_ff    != '0) ? l0_lim_ff    : DEF_L0_FILES;
   assign flush_bud = (flush_bud_ff != '0) ? flush_bud_ff : DEF_FLUSH_BUD;
   assign l0_bud    = (l0_bud_ff    != '0) ? l0_bud_ff    : DEF_L0_BUD;

   // ---------------- clearing pass ----------------
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(NUM_CPUS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // ---------------- stage 1 (memory data available) ----------------
   logic        s1_valid_ff;
   logic        s1_func_ff;
   logic [63:0] s1_now_ff, s1_mtime_ff, s1_bytes_ff, s1_l0files_ff;
   logic [5:0]  s1_cpu_ff;
   logic [1:0]  s1_class_ff;
   logic        s1_flz_ff, s1_mp_ff, s1_stall_ff;
   logic [31:0] s1_imm_ff;
   logic [4:0]  s1_qready_ff;

   logic rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic s1_adv, req_acc;
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_func_ff    <= req_tuser;
         s1_now_ff     <= req_tdata[63:0];
         s1_cpu_ff     <= req_tdata[69:64];
         s1_class_ff   <= req_tdata[71:70];
         s1_flz_ff     <= req_tdata[72];
         s1_mp_ff      <= req_tdata[73];
         s1_mtime_ff   <= req_tdata[137:74];
         s1_stall_ff   <= req_tdata[138];
         s1_imm_ff     <= req_tdata[170:139];
         s1_bytes_ff   <= req_tdata[234:171];
         s1_l0files_ff <= req_tdata[298:235];
         s1_qready_ff  <= req_tdata[303:299];
      end
   end

   // ---------------- counter memory ----------------
   cnt_word_type  rd_word, cnt_word, wr_word, upd_word;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] s1_idx;
   logic          upd_we;

   assign s1_idx    = AW'(s1_cpu_ff);
   assign mem_we    = clr_busy_ff || upd_we;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : s1_idx;
   assign wr_word   = clr_busy_ff ? cnt_word_type'('0) : upd_word;

   pqa_ram #(
      .WIDTH ($bits(cnt_word_type)),
      .DEPTH (NUM_CPUS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (wr_word),
      .rd_en   (req_acc),
      .rd_addr (AW'(req_tdata[69:64])),
      .rd_data (rd_word)
   );

   // most recent write; if its address matches it is the current content
   logic          byp_valid_ff;
   logic [AW-1:0] byp_addr_ff;
   cnt_word_type  byp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else if (upd_we) begin
         byp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_we) begin
         byp_addr_ff <= s1_idx;
         byp_word_ff <= upd_word;
      end
   end

   assign cnt_word = (byp_valid_ff && byp_addr_ff == s1_idx) ? byp_word_ff : rd_word;

   // ---------------- pressure window ----------------
   logic [63:0] flush_seen_ff, level0_seen_ff;
   logic [63:0] flush_seen_in, level0_seen_in;
   logic        f_ok, l_ok, now_nz, ba_cur, ba_enq;

   assign f_ok   = (flush_seen_ff != '0) && (s1_now_ff >= flush_seen_ff) &&
                   ((s1_now_ff - flush_seen_ff) < RECENT_SPAN_NS);
   assign l_ok   = (level0_seen_ff != '0) && (s1_now_ff >= level0_seen_ff) &&
                   ((s1_now_ff - level0_seen_ff) < RECENT_SPAN_NS);
   assign now_nz = (s1_now_ff != '0);
   assign ba_cur = f_ok && l_ok;

   // ---------------- classification ----------------
   logic          stale;
   task_kind_type kind;

   assign stale = !s1_mp_ff ? 1'b1 :
                  (s1_now_ff < s1_mtime_ff) ? 1'b0 :
                  ((s1_now_ff - s1_mtime_ff) > age_thr);

   always_comb begin
      kind = KIND_SHARED;
      case (s1_class_ff)
         CLS_FLUSH: begin
            if (!stale && (s1_stall_ff || s1_imm_ff >= imm_thr || s1_bytes_ff >= bytes_lvl)) begin
               kind = KIND_FLUSH;
            end
         end
         CLS_COMPACTION: begin
            if (s1_flz_ff && !stale && s1_l0files_ff >= l0_thr) begin
               kind = KIND_LEVEL0;
            end else begin
               kind = KIND_COMPACTION;
            end
         end
         default: kind = KIND_SHARED;
      endcase
   end

   // state after this item's stamp is recorded
   assign ba_enq = ((kind == KIND_FLUSH) ? now_nz : f_ok) &&
                   ((kind == KIND_LEVEL0) ? now_nz : l_ok);

   assign flush_seen_in  = (kind == KIND_FLUSH)  ? s1_now_ff : flush_seen_ff;
   assign level0_seen_in = (kind == KIND_LEVEL0) ? s1_now_ff : level0_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_seen_ff  <= '0;
         level0_seen_ff <= '0;
      end else if (s1_adv && s1_func_ff == FUNC_ENQUEUE) begin
         flush_seen_ff  <= flush_seen_in;
         level0_seen_ff <= level0_seen_in;
      end
   end

   // ---------------- dispatch ----------------
   logic     cpu_ok, q_l0, q_fl, q_cp, q_sh, q_rs;
   pick_type pick;
   run_type  run;
   logic     rec;

   assign cpu_ok = (32'(s1_cpu_ff) < 32'(NUM_CPUS));
   assign q_l0   = s1_qready_ff[0];
   assign q_fl   = s1_qready_ff[1];
   assign q_cp   = s1_qready_ff[2];
   assign q_sh   = s1_qready_ff[3];
   assign q_rs   = s1_qready_ff[4];

   always_comb begin
      pick = PICK_NONE;
      run  = RUN_OTHER;
      rec  = 1'b0;
      if (cpu_ok && cnt_word.flush_runs >= flush_bud && (q_l0 || q_cp || q_sh)) begin
         rec = 1'b1;
         if (q_l0) begin
            pick = PICK_LEVEL0;
            run  = RUN_LEVEL0;
         end else if (q_cp) begin
            pick = PICK_COMPACTION;
         end else begin
            pick = PICK_SHARED;
         end
      end else if (cpu_ok && cnt_word.level0_runs >= l0_bud &&
                   ((ba_cur && q_fl) || q_cp || q_sh)) begin
         rec = 1'b1;
         if (ba_cur && q_fl) begin
            pick = PICK_FLUSH;
            run  = RUN_FLUSH;
         end else if (q_cp) begin
            pick = PICK_COMPACTION;
         end else begin
            pick = PICK_SHARED;
         end
      end else if (ba_cur && q_l0) begin
         pick = PICK_LEVEL0;
         run  = RUN_LEVEL0;
         rec  = cpu_ok;
      end else if (q_fl) begin
         pick = PICK_FLUSH;
         run  = RUN_FLUSH;
         rec  = cpu_ok;
      end else if (q_l0) begin
         pick = PICK_LEVEL0;
         run  = RUN_LEVEL0;
         rec  = cpu_ok;
      end else if (q_rs) begin
         pick = PICK_RESCUE;
      end else if (q_cp) begin
         pick = PICK_COMPACTION;
         rec  = cpu_ok;
      end else if (q_sh) begin
         pick = PICK_SHARED;
      end
   end

   always_comb begin
      upd_word.flush_runs  = (run == RUN_FLUSH)  ? sat_inc(cnt_word.flush_runs)  : '0;
      upd_word.level0_runs = (run == RUN_LEVEL0) ? sat_inc(cnt_word.level0_runs) : '0;
   end
   assign upd_we = s1_adv && (s1_func_ff == FUNC_DISPATCH) && rec;

   // ---------------- result register ----------------
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   always_comb begin
      if (s1_func_ff == FUNC_ENQUEUE) begin
         rsp_data_in = {2'b00, ba_enq, PICK_NONE, kind};
      end else begin
         rsp_data_in = {2'b00, ba_cur, pick, KIND_SHARED};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_one_field_used: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == 2'd0 || rsp_tdata[4:2] == 3'd0))
      else $error("both task_kind and picked_queue set");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> clr_busy_ff && !req_tready)
      else $error("clearing pass not running after reset");

   a_no_update_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !upd_we && !s1_valid_ff)
      else $error("counter update during clearing pass");

   a_update_advances: assert property (@(posedge clock) disable iff (reset)
      upd_we |=> rsp_tvalid)
      else $error("counter written without a result");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the pressure-aware queue arbiter: directed and random scheduler events.
`timescale 1ns / 100ps
module testbench;
   import pqa_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   // bit positions inside queue_ready
   localparam int RDY_L0     = 0;
   localparam int RDY_FLUSH  = 1;
   localparam int RDY_COMP   = 2;
   localparam int RDY_SHARED = 3;
   localparam int RDY_RESCUE = 4;

   typedef struct {
      func_type         func;
      logic [63:0]      now;
      logic [5:0]       cpu;
      thread_class_type cls;
      logic             from_l0;
      logic             present;
      logic [63:0]      mtime;
      logic             stall;
      logic [31:0]      imm;
      logic [63:0]      bytes;
      logic [63:0]      files;
      logic [4:0]       qready;
   } sched_event_type;

   typedef struct {
      task_kind_type kind;
      pick_type      pick;
      logic          both;
   } queue_decision_type;

   class arbitration_scoreboard_type;
      logic [63:0] stale_after, bytes_limit, l0_file_limit;
      logic [31:0] imm_limit, flush_run_cap, l0_run_cap;
      logic [31:0] flush_runs [64];
      logic [31:0] level0_runs [64];
      logic [63:0] flush_seen, level0_seen;
      queue_decision_type pending_decisions [$];
      int errors;
      int responses;

      function new();
         stale_after   = DEF_AGE;
         bytes_limit   = DEF_BYTES;
         imm_limit     = DEF_IMM;
         l0_file_limit = DEF_L0_FILES;
         flush_run_cap = DEF_FLUSH_BUD;
         l0_run_cap    = DEF_L0_BUD;
         foreach (flush_runs[i]) begin
            flush_runs[i]  = '0;
            level0_runs[i] = '0;
         end
         flush_seen  = '0;
         level0_seen = '0;
         errors      = 0;
         responses   = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] v);
         case (idx)
            CSR_STALE_AGE:    stale_after   = v;
            CSR_BYTES_LIMIT:  bytes_limit   = v;
            CSR_IMM_LIMIT:    imm_limit     = v[31:0];
            CSR_L0_LIMIT:     l0_file_limit = v;
            CSR_FLUSH_CAP:    flush_run_cap = v[31:0];
            CSR_L0_CAP:       l0_run_cap    = v[31:0];
            default: ;
         endcase
      endfunction

      function logic both_recent(logic [63:0] t);
         if (flush_seen == 0 || level0_seen == 0)
            return 1'b0;
         if (t < flush_seen || t < level0_seen)
            return 1'b0;
         return (t - flush_seen < RECENT_SPAN_NS) && (t - level0_seen < RECENT_SPAN_NS);
      endfunction

      function logic is_stale(sched_event_type e);
         logic [63:0] lim;
         lim = (stale_after != 0) ? stale_after : DEF_AGE;
         if (!e.present)
            return 1'b1;
         // metrics stamped in the future never count as old
         if (e.now < e.mtime)
            return 1'b0;
         return (e.now - e.mtime) > lim;
      endfunction

      function task_kind_type sort_task(sched_event_type e);
         logic [63:0] bthr, fthr;
         logic [31:0] ithr;
         bthr = (bytes_limit != 0) ? bytes_limit : DEF_BYTES;
         fthr = (l0_file_limit != 0) ? l0_file_limit : DEF_L0_FILES;
         ithr = (imm_limit != 0) ? imm_limit : DEF_IMM;
         case (e.cls)
            CLS_FLUSH: begin
               if (is_stale(e))
                  return KIND_SHARED;
               if (e.stall || e.imm >= ithr || e.bytes >= bthr)
                  return KIND_FLUSH;
               return KIND_SHARED;
            end
            CLS_COMPACTION: begin
               if (e.from_l0 && !is_stale(e) && e.files >= fthr)
                  return KIND_LEVEL0;
               return KIND_COMPACTION;
            end
            default: return KIND_SHARED;
         endcase
      endfunction

      function void count_run(int c, run_type k);
         if (k == RUN_FLUSH)
            flush_runs[c] = (flush_runs[c] != CNT_MAX) ? flush_runs[c] + 32'd1 : flush_runs[c];
         else
            flush_runs[c] = '0;
         if (k == RUN_LEVEL0)
            level0_runs[c] = (level0_runs[c] != CNT_MAX) ? level0_runs[c] + 32'd1
                                                         : level0_runs[c];
         else
            level0_runs[c] = '0;
      endfunction

      function pick_type choose_queue(sched_event_type e, logic ba);
         logic [31:0] fb, lb;
         logic        l0, fl, cp, sh;
         int          c;
         c  = e.cpu;
         l0 = e.qready[RDY_L0];
         fl = e.qready[RDY_FLUSH];
         cp = e.qready[RDY_COMP];
         sh = e.qready[RDY_SHARED];
         fb = (flush_run_cap != 0) ? flush_run_cap : DEF_FLUSH_BUD;
         lb = (l0_run_cap != 0) ? l0_run_cap : DEF_L0_BUD;
         if (flush_runs[c] >= fb) begin
            if (l0) begin count_run(c, RUN_LEVEL0); return PICK_LEVEL0; end
            if (cp) begin count_run(c, RUN_OTHER); return PICK_COMPACTION; end
            if (sh) begin count_run(c, RUN_OTHER); return PICK_SHARED; end
         end
         if (level0_runs[c] >= lb) begin
            if (ba && fl) begin count_run(c, RUN_FLUSH); return PICK_FLUSH; end
            if (cp) begin count_run(c, RUN_OTHER); return PICK_COMPACTION; end
            if (sh) begin count_run(c, RUN_OTHER); return PICK_SHARED; end
         end
         // level 0 jumps ahead of flush only while both pressures are recent
         if (ba && l0) begin count_run(c, RUN_LEVEL0); return PICK_LEVEL0; end
         if (fl) begin count_run(c, RUN_FLUSH); return PICK_FLUSH; end
         if (!ba && l0) begin count_run(c, RUN_LEVEL0); return PICK_LEVEL0; end
         if (e.qready[RDY_RESCUE])
            return PICK_RESCUE;
         if (cp) begin count_run(c, RUN_OTHER); return PICK_COMPACTION; end
         if (sh)
            return PICK_SHARED;
         return PICK_NONE;
      endfunction

      function void note_event(sched_event_type e);
         queue_decision_type want;
         want.kind = KIND_SHARED;
         want.pick = PICK_NONE;
         if (e.func == FUNC_ENQUEUE) begin
            want.kind = sort_task(e);
            if (want.kind == KIND_FLUSH)
               flush_seen = e.now;
            else if (want.kind == KIND_LEVEL0)
               level0_seen = e.now;
            want.both = both_recent(e.now);
         end else begin
            want.both = both_recent(e.now);
            want.pick = choose_queue(e, want.both);
         end
         pending_decisions.push_back(want);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 50)
            $display("%0t: mismatch: %s", $time, what);
      endtask

      task check_response(logic [RSP_TDATA_W-1:0] d);
         queue_decision_type want;
         responses++;
         if (pending_decisions.size() == 0) begin
            report($sformatf("response %0d (%h) with nothing outstanding", responses, d));
            return;
         end
         want = pending_decisions.pop_front();
         if (d[1:0] !== want.kind)
            report($sformatf("response %0d task_kind %0d, want %0d", responses, d[1:0],
                             want.kind));
         if (d[4:2] !== want.pick)
            report($sformatf("response %0d picked_queue %0d, want %0d", responses, d[4:2],
                             want.pick));
         if (d[5] !== want.both)
            report($sformatf("response %0d both_active %b, want %b", responses, d[5],
                             want.both));
         if (d[7:6] !== 2'b00)
            report($sformatf("response %0d pad bits %b", responses, d[7:6]));
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [63:0]            csr_data   = '0;

   arbitration_scoreboard_type sb = new();
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          idle_cycles   = 0;
   logic [63:0] clock_ns      = 64'd20000000000;

   pressure_aware_queue_arbiter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (idle_cycles < WATCHDOG_LIMIT);
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic sched_event_type make_event(func_type f, logic [63:0] t, logic [5:0] c,
                                                  thread_class_type k, logic l0, logic pres,
                                                  logic [63:0] mt, logic st, logic [31:0] im,
                                                  logic [63:0] by, logic [63:0] fi,
                                                  logic [4:0] q);
      sched_event_type e;
      e.func = f;     e.now = t;       e.cpu = c;   e.cls = k;
      e.from_l0 = l0; e.present = pres; e.mtime = mt; e.stall = st;
      e.imm = im;     e.bytes = by;    e.files = fi; e.qready = q;
      return e;
   endfunction

   // time mostly creeps forward so that the 1 s window and staleness are hit often
   function automatic sched_event_type random_event();
      sched_event_type e;
      logic [63:0]  lim, bthr, fthr;
      logic [31:0]  ithr;
      int           sel;
      lim  = (sb.stale_after != 0) ? sb.stale_after : DEF_AGE;
      bthr = (sb.bytes_limit != 0) ? sb.bytes_limit : DEF_BYTES;
      fthr = (sb.l0_file_limit != 0) ? sb.l0_file_limit : DEF_L0_FILES;
      ithr = (sb.imm_limit != 0) ? sb.imm_limit : DEF_IMM;
      clock_ns = clock_ns + 64'($urandom_range(0, 100000000));
      sel = $urandom_range(0, 99);
      if (sel < 3)
         e.now = {$urandom, $urandom};
      else if (sel == 3)
         e.now = '0;
      else if (sel == 4)
         e.now = '1;
      else
         e.now = clock_ns;
      e.func    = func_type'($urandom_range(0, 1));
      e.cpu     = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 3));
      e.cls     = thread_class_type'($urandom_range(0, 3));
      e.from_l0 = ($urandom_range(0, 3) != 0);
      e.present = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 5))
         0: e.mtime = e.now - 64'($urandom_range(0, 3));
         1: e.mtime = e.now - lim + 64'($urandom_range(0, 2)) - 64'd1;
         2: e.mtime = e.now + 64'($urandom_range(1, 1000));
         3: e.mtime = {$urandom, $urandom};
         default: e.mtime = e.now - 64'($urandom_range(0, 500000000));
      endcase
      e.stall = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
         0: e.imm = $urandom;
         1: e.imm = ithr - 32'($urandom_range(0, 1));
         default: e.imm = 32'($urandom_range(0, 2));
      endcase
      case ($urandom_range(0, 3))
         0: e.bytes = {$urandom, $urandom};
         1: e.bytes = bthr - 64'($urandom_range(0, 2)) + 64'd1;
         default: e.bytes = 64'($urandom_range(0, 100000000));
      endcase
      case ($urandom_range(0, 3))
         0: e.files = {$urandom, $urandom};
         1: e.files = fthr - 64'($urandom_range(0, 2)) + 64'd1;
         default: e.files = 64'($urandom_range(0, 8));
      endcase
      e.qready = 5'($urandom_range(0, 31));
      return e;
   endfunction

   task automatic send_event(sched_event_type e);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= e.func;
      req_tdata  <= {e.qready, e.files, e.bytes, e.imm, e.stall, e.mtime, e.present,
                     e.from_l0, e.cls, e.cpu, e.now};
      do @(posedge clock); while (!req_tready);
      sb.note_event(e);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
   endtask

   task automatic settle();
      while (sb.pending_decisions.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      sched_event_type plan [$];
      logic [63:0]  cfg [6];
      logic [63:0]  t0;
      int           mode;
      t0 = 64'd10000000000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: classification corners, then budget and window behaviour
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_UNKNOWN, 1'b1, 1'b1, t0, 1'b1,
                                32'd5, DEF_BYTES, 64'd9, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_OTHER, 1'b1, 1'b1, t0, 1'b1,
                                32'd5, DEF_BYTES, 64'd9, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_FLUSH, 1'b0, 1'b0, t0, 1'b1,
                                32'd5, DEF_BYTES, 64'd0, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_FLUSH, 1'b0, 1'b1,
                                t0 - DEF_AGE - 64'd1, 1'b1, 32'd5, DEF_BYTES, 64'd0, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_FLUSH, 1'b0, 1'b1, t0 - DEF_AGE,
                                1'b0, 32'd0, DEF_BYTES - 64'd1, 64'd0, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_FLUSH, 1'b0, 1'b1, t0 - DEF_AGE,
                                1'b0, DEF_IMM, 64'd0, 64'd0, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_COMPACTION, 1'b1, 1'b0, t0, 1'b0,
                                32'd0, 64'd0, 64'd100, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_COMPACTION, 1'b0, 1'b1, t0, 1'b0,
                                32'd0, 64'd0, 64'd100, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0, 6'd0, CLS_COMPACTION, 1'b1, 1'b1, t0, 1'b0,
                                32'd0, 64'd0, DEF_L0_FILES - 64'd1, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0 + 64'd1, 6'd0, CLS_COMPACTION, 1'b1, 1'b1,
                                t0 + 64'd5, 1'b0, 32'd0, 64'd0, DEF_L0_FILES, 5'd0));
      plan.push_back(make_event(FUNC_ENQUEUE, t0 + 64'd2, 6'd0, CLS_FLUSH, 1'b0, 1'b1,
                                t0 + 64'd2, 1'b0, 32'd0, DEF_BYTES, 64'd0, 5'd0));
      repeat (3)
         plan.push_back(make_event(FUNC_DISPATCH, t0 + 64'd3, 6'd1, CLS_UNKNOWN, 1'b0, 1'b0,
                                   64'd0, 1'b0, 32'd0, 64'd0, 64'd0, 5'b00011));
      repeat (3)
         plan.push_back(make_event(FUNC_DISPATCH, t0 + 64'd2000000000, 6'd2, CLS_UNKNOWN,
                                   1'b0, 1'b0, 64'd0, 1'b0, 32'd0, 64'd0, 64'd0, 5'b00011));
      plan.push_back(make_event(FUNC_DISPATCH, t0 + 64'd2000000000, 6'd2, CLS_UNKNOWN, 1'b0,
                                1'b0, 64'd0, 1'b0, 32'd0, 64'd0, 64'd0, 5'b11111));
      plan.push_back(make_event(FUNC_DISPATCH, t0, 6'd63, CLS_UNKNOWN, 1'b0, 1'b0, 64'd0,
                                1'b0, 32'd0, 64'd0, 64'd0, 5'b10000));
      plan.push_back(make_event(FUNC_DISPATCH, t0, 6'd63, CLS_UNKNOWN, 1'b0, 1'b0, 64'd0,
                                1'b0, 32'd0, 64'd0, 64'd0, 5'b01000));
      plan.push_back(make_event(FUNC_DISPATCH, t0, 6'd63, CLS_UNKNOWN, 1'b0, 1'b0, 64'd0,
                                1'b0, 32'd0, 64'd0, 64'd0, 5'b00000));
      plan.push_back(make_event(FUNC_DISPATCH, t0, 6'd63, CLS_UNKNOWN, 1'b0, 1'b0, 64'd0,
                                1'b0, 32'd0, 64'd0, 64'd0, 5'b00100));
      plan.push_back(make_event(FUNC_DISPATCH, 64'd0, 6'd3, CLS_UNKNOWN, 1'b0, 1'b0, 64'd0,
                                1'b0, 32'd0, 64'd0, 64'd0, 5'b00001));
      plan.push_back(make_event(FUNC_ENQUEUE, '1, '1, CLS_OTHER, 1'b1, 1'b1, '1, 1'b1, '1,
                                '1, '1, '1));
      plan.push_back(make_event(FUNC_DISPATCH, '1, '1, CLS_OTHER, 1'b1, 1'b1, '1, 1'b1, '1,
                                '1, '1, '1));
      foreach (plan[i])
         send_event(plan[i]);
      req_tvalid <= 1'b0;
      // hold off until every decision is back
      settle();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: foreach (cfg[k]) cfg[k] = '0;
            1: foreach (cfg[k]) cfg[k] = '1;
            2: foreach (cfg[k]) cfg[k] = 64'd1;
            default: begin
               cfg[CSR_STALE_AGE]    = 64'($urandom_range(200000000, 2000000000));
               cfg[CSR_BYTES_LIMIT]  = 64'($urandom_range(1, 200000000));
               cfg[CSR_IMM_LIMIT]    = {$urandom, 32'($urandom_range(0, 4))};
               cfg[CSR_L0_LIMIT]     = 64'($urandom_range(0, 8));
               cfg[CSR_FLUSH_CAP]    = {$urandom, 32'($urandom_range(ph - 3, 5))};
               cfg[CSR_L0_CAP]       = {$urandom, 32'($urandom_range(ph - 3, 5))};
            end
         endcase
         for (int k = CSR_STALE_AGE; k <= CSR_L0_CAP; k++)
            write_csr(CSR_IDX_W'(k), cfg[k]);
         // unmapped indexes must leave every register alone
         if (ph == 0)
            for (int k = CSR_L0_CAP + 1; k < 2 ** CSR_IDX_W; k++)
               write_csr(CSR_IDX_W'(k), {$urandom, $urandom});
         csr_valid <= 1'b0;
         for (int n = 0; n < ((ph == 4) ? 680 : 300); n++) begin
            if (n % 50 == 0) begin
               mode = (ph < 4) ? ph : $urandom_range(0, 3);
               case (mode)
                  0: begin send_idle_pct = 0;  stall_pct = 0;  end
                  1: begin send_idle_pct = 54; stall_pct = 0;  end
                  2: begin send_idle_pct = 0;  stall_pct = 54; end
                  default: begin send_idle_pct = 36; stall_pct = 36; end
               endcase
            end
            send_event(random_event());
         end
         req_tvalid <= 1'b0;
         settle();
      end

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
